[rtl/core/gregorian_julian_day_converter_top_macros.svh]
// Assertion helpers used by the converter top module.
// Both expect the module's clock i_clk and active-low reset i_rst_n in scope.
`ifndef GREGORIAN_JULIAN_DAY_CONVERTER_TOP_MACROS_SVH
`define GREGORIAN_JULIAN_DAY_CONVERTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GJD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gjd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GJD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gjd: next-cycle check failed");

`endif

[rtl/core/gjd_pkg.sv]
package gjd_pkg;

    // Time units in milliseconds
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;

    // Calendar cycle lengths in days
    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;
    localparam logic [7:0]  DAYS_5M   = 8'd153;

    // Reciprocals floor(2^k / divisor); the quotient lands at most one low
    localparam logic [8:0]  RCP_400Y  = 9'd459;    // k = 26
    localparam logic [7:0]  RCP_4Y    = 8'd179;    // k = 18
    localparam logic [3:0]  RCP_5M    = 4'd13;     // k = 11
    localparam logic [5:0]  RCP_HOUR  = 6'd37;     // k = 27
    localparam logic [6:0]  RCP_MIN   = 7'd69;     // k = 22
    // floor(y * 5243 / 2^19) equals y / 100 for every 14-bit year
    localparam logic [12:0] RCP_CENT  = 13'd5243;

    localparam logic [23:0] JDN_BIAS   = 24'd32044;
    localparam logic [14:0] YEAR_BIAS  = 15'd4716;
    localparam logic [13:0] EPOCH_YEAR = 14'd4800;
    localparam logic [6:0]  CENTURY    = 7'd100;
    // 1524 less the constant 2 of the century correction
    localparam logic [22:0] DN_BIAS    = 23'd1522;
    localparam logic [3:0]  MONTH_MAR  = 4'd3;
    localparam logic [3:0]  MONTH_WRAP = 4'd10;

    // Register stages from the day-carry stage to the calendar result
    localparam int unsigned CORE_LAT = 9;
    // Stages of the calendar-to-day path, and the padding that aligns it
    localparam int unsigned D2J_LAT  = 3;
    localparam int unsigned D2J_PAD  = CORE_LAT - D2J_LAT;

    typedef struct packed {
        logic        action;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [22:0] day_number;
        logic [26:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [22:0] out_day_number;
        logic [26:0] out_time_ms;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_second_ms;
    } t_out_item;

    // Calendar result of the day-to-calendar path
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [26:0] time_ms;
    } t_cal;

    // floor(30.6001 * (m + 1)) for m, the March-based month plus three
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd30;
            4'd1:    v = 9'd61;
            4'd2:    v = 9'd91;
            4'd3:    v = 9'd122;
            4'd4:    v = 9'd153;
            4'd5:    v = 9'd183;
            4'd6:    v = 9'd214;
            4'd7:    v = 9'd244;
            4'd8:    v = 9'd275;
            4'd9:    v = 9'd306;
            4'd10:   v = 9'd336;
            4'd11:   v = 9'd367;
            4'd12:   v = 9'd397;
            4'd13:   v = 9'd428;
            4'd14:   v = 9'd459;
            4'd15:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor((153 * m + 2) / 5): days before month m of a March-based year
    function automatic logic [8:0] day_term(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd398;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/gjd_date2jd.sv]
module gjd_date2jd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [14:0] i_u,        // adjusted year plus 4716
    input  logic [13:0] i_yc,       // adjusted year, clamped at zero
    input  logic [3:0]  i_m,        // March-based month plus three
    input  logic [4:0]  i_d,
    input  logic        i_carry,
    output logic [22:0] o_dn
);
    import gjd_pkg::*;

    logic [25:0] prd_t1;
    logic [26:0] n_q1_cp;
    logic [22:0] n_q1_t1;
    logic [8:0]  n_q1_mt;
    logic [26:0] r_q1_cp;
    logic [22:0] r_q1_t1;
    logic [8:0]  r_q1_mt;
    logic [4:0]  r_q1_d;
    logic        r_q1_c;

    logic [22:0] n_q2_s;
    logic [7:0]  r_q2_cen;
    logic [22:0] r_q2_s;

    logic [22:0] n_q3_dn;
    logic [22:0] r_q3_dn;

    logic [D2J_PAD-1:0][22:0] r_pad;

    // Century product, four-year day count and month term in parallel
    assign prd_t1  = 26'(i_u) * 26'(DAYS_4Y);
    assign n_q1_t1 = prd_t1[24:2];
    assign n_q1_cp = 27'(i_yc) * 27'(RCP_CENT);
    assign n_q1_mt = month_term(i_m);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1_cp <= n_q1_cp;
            r_q1_t1 <= n_q1_t1;
            r_q1_mt <= n_q1_mt;
            r_q1_d  <= i_d;
            r_q1_c  <= i_carry;
        end
    end

    assign n_q2_s = r_q1_t1 + 23'(r_q1_mt) + 23'(r_q1_d) + 23'(r_q1_c) - DN_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q2_cen <= r_q1_cp[26:19];
            r_q2_s   <= n_q2_s;
        end
    end

    // Apply the century correction: minus A plus A / 4
    assign n_q3_dn = r_q2_s - 23'(r_q2_cen) + 23'(r_q2_cen[7:2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q3_dn <= n_q3_dn;
            r_pad   <= {r_pad[D2J_PAD-2:0], r_q3_dn};
        end
    end

    assign o_dn = r_pad[D2J_PAD-1];

endmodule

[rtl/core/gjd_jd2date.sv]
module gjd_jd2date (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [22:0]   i_dn,
    input  logic          i_carry,
    input  logic [26:0]   i_t,
    output gjd_pkg::t_cal o_cal
);
    import gjd_pkg::*;

    // P1: shift the day, estimate 400-year count and hour
    logic [23:0] sum_a;
    logic [25:0] n_p1_x;
    logic [34:0] prd_b;
    logic [32:0] prd_h;
    logic [25:0] r_p1_x;
    logic [7:0]  r_p1_bq;
    logic [4:0]  r_p1_hq;
    logic [26:0] r_p1_t;

    assign sum_a  = 24'(i_dn) + JDN_BIAS + 24'(i_carry);
    assign n_p1_x = {sum_a, 2'b11};
    assign prd_b  = 35'(n_p1_x) * 35'(RCP_400Y);
    assign prd_h  = 33'(i_t) * 33'(RCP_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_x  <= n_p1_x;
            r_p1_bq <= prd_b[33:26];
            r_p1_hq <= prd_h[31:27];
            r_p1_t  <= i_t;
        end
    end

    // P2: remainders of the estimates
    logic [25:0] n_p2_br;
    logic [26:0] n_p2_hr;
    logic [18:0] r_p2_br;
    logic [22:0] r_p2_hr;
    logic [7:0]  r_p2_bq;
    logic [4:0]  r_p2_hq;
    logic [26:0] r_p2_t;

    assign n_p2_br = r_p1_x - 26'(r_p1_bq) * 26'(DAYS_400Y);
    assign n_p2_hr = r_p1_t - 27'(r_p1_hq) * 27'(MS_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_br <= n_p2_br[18:0];
            r_p2_hr <= n_p2_hr[22:0];
            r_p2_bq <= r_p1_bq;
            r_p2_hq <= r_p1_hq;
            r_p2_t  <= r_p1_t;
        end
    end

    // P3: correct the estimates by one where the remainder overshoots
    logic        b_ge;
    logic        h_ge;
    logic [18:0] b_rem;
    logic [22:0] h_rem;
    logic [7:0]  r_p3_b;
    logic [17:0] r_p3_x2;
    logic [4:0]  r_p3_hour;
    logic [21:0] r_p3_rem;
    logic [26:0] r_p3_t;

    assign b_ge  = r_p2_br >= 19'(DAYS_400Y);
    assign b_rem = b_ge ? r_p2_br - 19'(DAYS_400Y) : r_p2_br;
    assign h_ge  = r_p2_hr >= 23'(MS_PER_HOUR);
    assign h_rem = h_ge ? r_p2_hr - 23'(MS_PER_HOUR) : r_p2_hr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3_b    <= r_p2_bq + 8'(b_ge);
            r_p3_x2   <= {b_rem[17:2], 2'b11};
            r_p3_hour <= r_p2_hq + 5'(h_ge);
            r_p3_rem  <= h_rem[21:0];
            r_p3_t    <= r_p2_t;
        end
    end

    // P4: estimate four-year count and minute, form the century part of the year
    logic [25:0] prd_d;
    logic [28:0] prd_m;
    logic [14:0] prd_y;
    logic [13:0] n_p4_yb;
    logic [17:0] r_p4_x2;
    logic [6:0]  r_p4_dq;
    logic [13:0] r_p4_yb;
    logic [21:0] r_p4_rem;
    logic [5:0]  r_p4_mq;
    logic [4:0]  r_p4_hour;
    logic [26:0] r_p4_t;

    assign prd_d   = 26'(r_p3_x2) * 26'(RCP_4Y);
    assign prd_m   = 29'(r_p3_rem) * 29'(RCP_MIN);
    assign prd_y   = 15'(r_p3_b) * 15'(CENTURY);
    assign n_p4_yb = prd_y[13:0] - EPOCH_YEAR;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p4_x2   <= r_p3_x2;
            r_p4_dq   <= prd_d[24:18];
            r_p4_yb   <= n_p4_yb;
            r_p4_rem  <= r_p3_rem;
            r_p4_mq   <= prd_m[27:22];
            r_p4_hour <= r_p3_hour;
            r_p4_t    <= r_p3_t;
        end
    end

    // P5: remainders
    logic [17:0] n_p5_dr;
    logic [21:0] n_p5_mr;
    logic [11:0] r_p5_dr;
    logic [6:0]  r_p5_dq;
    logic [16:0] r_p5_mr;
    logic [5:0]  r_p5_mq;
    logic [13:0] r_p5_yb;
    logic [4:0]  r_p5_hour;
    logic [26:0] r_p5_t;

    assign n_p5_dr = r_p4_x2 - 18'(r_p4_dq) * 18'(DAYS_4Y);
    assign n_p5_mr = r_p4_rem - 22'(r_p4_mq) * 22'(MS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p5_dr   <= n_p5_dr[11:0];
            r_p5_dq   <= r_p4_dq;
            r_p5_mr   <= n_p5_mr[16:0];
            r_p5_mq   <= r_p4_mq;
            r_p5_yb   <= r_p4_yb;
            r_p5_hour <= r_p4_hour;
            r_p5_t    <= r_p4_t;
        end
    end

    // P6: correct, take the day of the year and the seconds
    logic        d_ge;
    logic        m_ge;
    logic [11:0] d_rem;
    logic [16:0] m_rem;
    logic [8:0]  n_p6_e;
    logic [10:0] n_p6_x3;
    logic [6:0]  r_p6_d;
    logic [8:0]  r_p6_e;
    logic [10:0] r_p6_x3;
    logic [13:0] r_p6_yb;
    logic [4:0]  r_p6_hour;
    logic [5:0]  r_p6_minute;
    logic [15:0] r_p6_sec;
    logic [26:0] r_p6_t;

    assign d_ge    = r_p5_dr >= 12'(DAYS_4Y);
    assign d_rem   = d_ge ? r_p5_dr - 12'(DAYS_4Y) : r_p5_dr;
    assign n_p6_e  = d_rem[10:2];
    assign n_p6_x3 = {n_p6_e, 2'b10} + 11'(n_p6_e);
    assign m_ge    = r_p5_mr >= 17'(MS_PER_MIN);
    assign m_rem   = m_ge ? r_p5_mr - 17'(MS_PER_MIN) : r_p5_mr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p6_d      <= r_p5_dq + 7'(d_ge);
            r_p6_e      <= n_p6_e;
            r_p6_x3     <= n_p6_x3;
            r_p6_yb     <= r_p5_yb;
            r_p6_hour   <= r_p5_hour;
            r_p6_minute <= r_p5_mq + 6'(m_ge);
            r_p6_sec    <= m_rem[15:0];
            r_p6_t      <= r_p5_t;
        end
    end

    // P7: estimate the March-based month, add the four-year count to the year
    logic [14:0] prd_mo;
    logic [3:0]  r_p7_mq;
    logic [10:0] r_p7_x3;
    logic [8:0]  r_p7_e;
    logic [13:0] r_p7_yb;
    logic [4:0]  r_p7_hour;
    logic [5:0]  r_p7_minute;
    logic [15:0] r_p7_sec;
    logic [26:0] r_p7_t;

    assign prd_mo = 15'(r_p6_x3) * 15'(RCP_5M);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p7_mq     <= prd_mo[14:11];
            r_p7_x3     <= r_p6_x3;
            r_p7_e      <= r_p6_e;
            r_p7_yb     <= r_p6_yb + 14'(r_p6_d);
            r_p7_hour   <= r_p6_hour;
            r_p7_minute <= r_p6_minute;
            r_p7_sec    <= r_p6_sec;
            r_p7_t      <= r_p6_t;
        end
    end

    // P8: month remainder
    logic [10:0] n_p8_mr;
    logic [8:0]  r_p8_mr;
    logic [3:0]  r_p8_mq;
    logic [8:0]  r_p8_e;
    logic [13:0] r_p8_yb;
    logic [4:0]  r_p8_hour;
    logic [5:0]  r_p8_minute;
    logic [15:0] r_p8_sec;
    logic [26:0] r_p8_t;

    assign n_p8_mr = r_p7_x3 - 11'(r_p7_mq) * 11'(DAYS_5M);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p8_mr     <= n_p8_mr[8:0];
            r_p8_mq     <= r_p7_mq;
            r_p8_e      <= r_p7_e;
            r_p8_yb     <= r_p7_yb;
            r_p8_hour   <= r_p7_hour;
            r_p8_minute <= r_p7_minute;
            r_p8_sec    <= r_p7_sec;
            r_p8_t      <= r_p7_t;
        end
    end

    // P9: settle the month and map it back to January-based numbering
    logic        mo_ge;
    logic [3:0]  mo;
    logic        mo_wrap;
    logic [9:0]  day_sum;
    t_cal        n_p9_cal;
    t_cal        r_p9_cal;

    assign mo_ge   = r_p8_mr >= 9'(DAYS_5M);
    assign mo      = r_p8_mq + 4'(mo_ge);
    assign mo_wrap = mo >= MONTH_WRAP;
    assign day_sum = 10'(r_p8_e) - 10'(day_term(mo)) + 10'd1;

    always_comb begin
        n_p9_cal.year      = r_p8_yb + 14'(mo_wrap);
        n_p9_cal.month     = mo_wrap ? mo - (MONTH_WRAP - 4'd1) : mo + MONTH_MAR;
        n_p9_cal.day       = day_sum[4:0];
        n_p9_cal.hour      = r_p8_hour;
        n_p9_cal.minute    = r_p8_minute;
        n_p9_cal.second_ms = r_p8_sec;
        n_p9_cal.time_ms   = r_p8_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p9_cal <= n_p9_cal;
        end
    end

    assign o_cal = r_p9_cal;

endmodule

[rtl/core/gregorian_julian_day_converter_top.sv]
// Twelve register stages from i_item to o_item. Each division by a calendar constant on the
// day-to-calendar path is a reciprocal multiply, a remainder and a one-step correction, each
// in a stage of its own. Throughput: one item per cycle unless i_stall holds back a result.
// A stalled result freezes every stage at once, so a full pipe holds twelve items.
// Reset (i_rst_n low, synchronous) clears the valid bits only; payload is not reset.
`include "gregorian_julian_day_converter_top_macros.svh"

module gregorian_julian_day_converter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  gjd_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output gjd_pkg::t_out_item o_item
);
    import gjd_pkg::*;

    localparam int unsigned NSTG = CORE_LAT + 3;

    // Pipe advance: everything moves unless a finished result is held back
    logic en;
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-2:0]   r_act;
    logic              r_oact;

    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_act  <= {r_act[NSTG-3:0], i_item.action};
            r_oact <= r_act[NSTG-2];
        end
    end

    // Stage 1: build the time of day and fold January and February into the
    // previous year. Year zero in those months leaves a century of zero.
    logic        jan_feb;
    logic [26:0] n_r1_t;
    logic [14:0] n_r1_u;
    logic [13:0] n_r1_yc;
    logic [3:0]  n_r1_m;
    logic [26:0] r1_t;
    logic [14:0] r1_u;
    logic [13:0] r1_yc;
    logic [3:0]  r1_m;
    logic [4:0]  r1_d;
    logic [22:0] r1_dn;

    assign jan_feb = i_item.month <= 4'd2;

    always_comb begin
        if (i_item.action) begin
            n_r1_t = i_item.time_ms;
        end else begin
            n_r1_t = 27'(i_item.hour) * 27'(MS_PER_HOUR)
                   + 27'(i_item.minute) * 27'(MS_PER_MIN)
                   + 27'(i_item.second_ms);
        end
        n_r1_u = 15'(i_item.year) + YEAR_BIAS - 15'(jan_feb);
        if (!jan_feb) begin
            n_r1_yc = i_item.year;
        end else if (i_item.year == 14'd0) begin
            n_r1_yc = 14'd0;
        end else begin
            n_r1_yc = i_item.year - 14'd1;
        end
        n_r1_m = jan_feb ? i_item.month + 4'd12 : i_item.month;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t  <= n_r1_t;
            r1_u  <= n_r1_u;
            r1_yc <= n_r1_yc;
            r1_m  <= n_r1_m;
            r1_d  <= i_item.day;
            r1_dn <= i_item.day_number;
        end
    end

    // Stage 2: carry a whole day out of the time; it is never more than one
    logic        day_ge;
    logic [26:0] r2_t;
    logic        r2_carry;
    logic [14:0] r2_u;
    logic [13:0] r2_yc;
    logic [3:0]  r2_m;
    logic [4:0]  r2_d;
    logic [22:0] r2_dn;

    assign day_ge = r1_t >= MS_PER_DAY;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t     <= day_ge ? r1_t - MS_PER_DAY : r1_t;
            r2_carry <= day_ge;
            r2_u     <= r1_u;
            r2_yc    <= r1_yc;
            r2_m     <= r1_m;
            r2_d     <= r1_d;
            r2_dn    <= r1_dn;
        end
    end

    // Both directions run on every item; the action picks the result at the end
    logic [22:0] cal_dn;
    t_cal        dn_cal;

    gjd_date2jd u_date2jd (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_u     (r2_u),
        .i_yc    (r2_yc),
        .i_m     (r2_m),
        .i_d     (r2_d),
        .i_carry (r2_carry),
        .o_dn    (cal_dn)
    );

    gjd_jd2date u_jd2date (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dn    (r2_dn),
        .i_carry (r2_carry),
        .i_t     (r2_t),
        .o_cal   (dn_cal)
    );

    // Output register: drop the fields the other direction owns to zero
    t_out_item n_out;
    t_out_item r_out;

    always_comb begin
        n_out.out_time_ms = dn_cal.time_ms;
        if (r_act[NSTG-2]) begin
            n_out.out_day_number = '0;
            n_out.out_year       = dn_cal.year;
            n_out.out_month      = dn_cal.month;
            n_out.out_day        = dn_cal.day;
            n_out.out_hour       = dn_cal.hour;
            n_out.out_minute     = dn_cal.minute;
            n_out.out_second_ms  = dn_cal.second_ms;
        end else begin
            n_out.out_day_number = cal_dn;
            n_out.out_year       = '0;
            n_out.out_month      = '0;
            n_out.out_day        = '0;
            n_out.out_hour       = '0;
            n_out.out_minute     = '0;
            n_out.out_second_ms  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

    // A held result freezes the valid and action lines together
    `GJD_ASSERT_NEXT(a_freeze, r_vld[NSTG-1] && i_stall, $stable(r_vld) && $stable(r_act))
    // The day carry always leaves a time of day below one day
    `GJD_ASSERT_NOW(a_time_of_day, o_valid, o_item.out_time_ms < MS_PER_DAY)
    // The hour and minute splits are fully corrected
    `GJD_ASSERT_NOW(a_clock_split, o_valid && r_oact,
        o_item.out_hour < 5'd24 && o_item.out_minute < 6'd60 &&
        o_item.out_second_ms < MS_PER_MIN)
    // The month estimate is corrected and mapped back into the year
    `GJD_ASSERT_NOW(a_month_day, o_valid && r_oact,
        o_item.out_month >= 4'd1 && o_item.out_month <= 4'd12 && o_item.out_day != 5'd0)

endmodule

[test/gregorian_julian_day_converter_top_tb.sv]
`timescale 1ns / 1ps

module gregorian_julian_day_converter_top_tb;
    import gjd_pkg::*;

    // Conversion direction carried in the action field
    localparam logic ACT_TO_DAY = 1'b0;
    localparam logic ACT_TO_CAL = 1'b1;

    localparam longint DAY_MS  = 86400000;
    localparam longint HOUR_MS = 3600000;
    localparam longint MIN_MS  = 60000;

    // Receiver hold-off long enough to fill all twelve stages and back up the input
    localparam int HOLD_OFF_CYCLES = 80;
    // Cycles to linger once every result is in
    localparam int TAIL_CYCLES     = 30;
    localparam int MAX_REPORTS     = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_item;

    // Results predicted for accepted items, oldest first
    t_out_item  expected_results[$];
    int         mismatch_count = 0;

    // Traffic shaping, per cent of cycles
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_off_left  = 0;

    gregorian_julian_day_converter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #6 i_clk = ~i_clk;

    // Predict one result: calendar to day number, or day number to calendar.
    // Work in signed 64-bit so that division truncates towards zero throughout.
    function automatic t_out_item convert_item(input t_in_item it);
        t_out_item r;
        longint    y, m, d, t, hr, mn, cen, corr, dn;
        longint    jdn, a, b, c, q, e, mm, yr, mo, dy, sc;
        r = '0;
        if (it.action == ACT_TO_DAY) begin
            y  = longint'(it.year);
            m  = longint'(it.month);
            d  = longint'(it.day);
            hr = longint'(it.hour);
            mn = longint'(it.minute);
            t  = longint'(it.second_ms);
            t  = hr * HOUR_MS + mn * MIN_MS + t;
            // January and February count as months 13 and 14 of the year before
            if (m <= 2) begin
                y = y - 1;
                m = m + 12;
            end
            cen  = y / 100;
            corr = 2 - cen + cen / 4;
            dn   = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d + corr - 1524;
            // carry whole days out of the time of day
            dn   = dn + t / DAY_MS;
            t    = t % DAY_MS;
            r.out_day_number = dn[22:0];
            r.out_time_ms    = t[26:0];
        end else begin
            t   = longint'(it.time_ms);
            jdn = longint'(it.day_number);
            jdn = jdn + t / DAY_MS;
            t   = t % DAY_MS;
            a   = jdn + 32044;
            b   = (4 * a + 3) / 146097;
            c   = a - (146097 * b) / 4;
            q   = (4 * c + 3) / 1461;
            e   = c - (1461 * q) / 4;
            mm  = (5 * e + 2) / 153;
            yr  = 100 * b + q - 4800 + mm / 10;
            mo  = mm + 3 - 12 * (mm / 10);
            dy  = e - (153 * mm + 2) / 5 + 1;
            hr  = t / HOUR_MS;
            mn  = (t % HOUR_MS) / MIN_MS;
            sc  = t % MIN_MS;
            r.out_time_ms   = t[26:0];
            r.out_year      = yr[13:0];
            r.out_month     = mo[3:0];
            r.out_day       = dy[4:0];
            r.out_hour      = hr[4:0];
            r.out_minute    = mn[5:0];
            r.out_second_ms = sc[15:0];
        end
        return r;
    endfunction

    function automatic string fmt_result(input t_out_item r);
        return $sformatf("dn=%0d t=%0d y=%0d m=%0d d=%0d h=%0d mi=%0d s=%0d",
                         r.out_day_number, r.out_time_ms, r.out_year, r.out_month,
                         r.out_day, r.out_hour, r.out_minute, r.out_second_ms);
    endfunction

    // Fill every field with noise first, so that unused fields toggle too
    function automatic t_in_item noise_item();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item make_cal(input int y, input int m, input int d,
                                          input int h, input int mi, input int s);
        t_in_item it;
        it           = noise_item();
        it.action    = ACT_TO_DAY;
        it.year      = 14'(y);
        it.month     = 4'(m);
        it.day       = 5'(d);
        it.hour      = 5'(h);
        it.minute    = 6'(mi);
        it.second_ms = 16'(s);
        return it;
    endfunction

    function automatic t_in_item make_dn(input int dn, input int t);
        t_in_item it;
        it            = noise_item();
        it.action     = ACT_TO_CAL;
        it.day_number = 23'(dn);
        it.time_ms    = 27'(t);
        return it;
    endfunction

    // Mostly well-formed dates and day numbers, one in ten pure noise
    function automatic t_in_item random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return make_cal($urandom_range(9999, 1), $urandom_range(12, 1),
                            $urandom_range(31, 1), $urandom_range(23, 0),
                            $urandom_range(59, 0), $urandom_range(59999, 0));
        else if (pick < 90)
            return make_dn($urandom_range(5373484, 1721426), $urandom_range(86399999, 0));
        else
            return noise_item();
    endfunction

    // Offer one item, idling first at the current rate; return at the falling
    // edge after acceptance with valid still high
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item  = it;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_results.push_back(convert_item(it));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_valid = 1'b0;
    endtask

    // Hold until every predicted result has been checked
    task automatic wait_drain();
        stop_sending();
        while (expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_calendar_extremes();
        send_item(make_cal(1, 1, 1, 0, 0, 0));
        send_item(make_cal(9999, 12, 31, 23, 59, 59999));
        send_item(make_cal(2000, 1, 1, 12, 0, 0));
        send_item(make_cal(2000, 2, 29, 0, 0, 0));
        send_item(make_cal(1582, 10, 15, 0, 0, 0));
        send_item(make_cal(1900, 3, 1, 6, 30, 30500));
        wait_drain();
    endtask

    task automatic test_calendar_special_cases();
        // month zero and the top month code
        send_item(make_cal(2021, 0, 15, 1, 2, 3));
        send_item(make_cal(2021, 15, 31, 4, 5, 6));
        // year zero in January and February: century of year minus one
        send_item(make_cal(0, 1, 1, 0, 0, 0));
        send_item(make_cal(0, 2, 28, 23, 59, 59999));
        // time of day past midnight carries into the day number
        send_item(make_cal(2020, 6, 15, 31, 63, 65535));
        // every field at full width, and day zero
        send_item(make_cal(16383, 15, 31, 31, 63, 65535));
        send_item(make_cal(2020, 3, 0, 0, 0, 0));
        wait_drain();
    endtask

    task automatic test_day_number_extremes();
        send_item(make_dn(1721426, 0));
        send_item(make_dn(5373484, 86399999));
        send_item(make_dn(2451545, 43200000));
        send_item(make_dn(2299161, 0));
        // exactly one day of time, then the largest time code
        send_item(make_dn(2451544, 86400000));
        send_item(make_dn(2451544, 27'h7FFFFFF));
        // day numbers outside the calendar range wrap the year
        send_item(make_dn(0, 0));
        send_item(make_dn(23'h7FFFFF, 27'h7FFFFFF));
        wait_drain();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_item(random_item());
        wait_drain();
    endtask

    // Freeze the output for a long stretch while items keep coming, so the
    // pipe fills and the input stalls; then pause until everything drains
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_off_left = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        repeat (50)
            send_item(random_item());
        wait_drain();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall       = 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %s", $realtime, fmt_result(o_item));
            end else begin
                want = expected_results.pop_front();
                if (o_item !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(o_item));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item  = '0;
        repeat (9)
            @(negedge i_clk);
        i_rst_n = 1'b1;

        test_calendar_extremes();
        test_calendar_special_cases();
        test_day_number_extremes();
        test_random_phase(250, 0, 0);
        test_random_phase(250, 65, 0);
        test_back_pressure();
        test_random_phase(250, 0, 65);
        test_random_phase(250, 38, 38);

        // drain with the receiver open, then let any stray result surface
        recv_stall_pct = 0;
        wait_drain();
        repeat (TAIL_CYCLES)
            @(negedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: the slowest correct run takes well under a tenth of this
    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
